// ===== rtl/gms_pkg.sv =====
// Package for the grid mark store: sizes, opcodes, error codes, back stage states
// and the command record passed from the front stage to the back stage. No dependencies.
`default_nettype none
package gms_pkg;
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam int IDX_W  = 6;
    localparam int CFG_W  = 7;
    localparam int CNT_W  = 7;
    localparam int TOT_W  = 13;

    localparam logic [1:0] OP_FILL  = 2'd0;
    localparam logic [1:0] OP_BLANK = 2'd1;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_RANGE    = 2'd1;
    localparam logic [1:0] ERR_CONFLICT = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [1:0] { ST_CLEAR, ST_READ, ST_UPDATE, ST_HOLD } st_t;

    typedef struct packed {
        logic             range_err;
        logic             wr_fill;
        logic             wr_blank;
        logic             mark;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [CFG_W-1:0] nr;
        logic [CFG_W-1:0] nc;
    } cmd_t;
endpackage
`default_nettype wire

// ===== rtl/grid_mark_store_with_line_counts.sv =====
// Grid mark store top level: front classifier, two-entry queue, back updater.
// The back stage reads then updates its mark memory per item and takes no new
// item until that update is done; a held output stalls it in between.
// After reset the back stage clears all 4096 cells before taking items;
// sizes reset to 64 by 64. Depends on gms_pkg, gms_front, gms_back.
`default_nettype none
module grid_mark_store_with_line_counts #(
    parameter int MAX_ROWS = gms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gms_pkg::MAX_COLS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [gms_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 opcode,
    input  wire logic [gms_pkg::IDX_W-1:0]  row_index,
    input  wire logic [gms_pkg::IDX_W-1:0]  col_index,
    input  wire logic                       mark_value,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      error_code,
    output logic                            cell_filled,
    output logic                            cell_blank,
    output logic [gms_pkg::CNT_W-1:0]       row_unknown,
    output logic [gms_pkg::CNT_W-1:0]       row_filled,
    output logic [gms_pkg::CNT_W-1:0]       row_blank,
    output logic [gms_pkg::CNT_W-1:0]       col_unknown,
    output logic [gms_pkg::CNT_W-1:0]       col_filled,
    output logic [gms_pkg::CNT_W-1:0]       col_blank,
    output logic [gms_pkg::TOT_W-1:0]       total_unknown,
    output logic [gms_pkg::TOT_W-1:0]       total_filled,
    output logic [gms_pkg::TOT_W-1:0]       total_blank
);
    import gms_pkg::*;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    gms_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
        .valid(in_valid), .ready(in_ready),
        .opcode, .row_index, .col_index, .mark_value,
        .cmd_valid, .cmd_ready, .cmd
    );

    gms_back u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
        .out_valid, .out_ready, .error_code, .cell_filled, .cell_blank,
        .row_unknown, .row_filled, .row_blank, .col_unknown, .col_filled, .col_blank,
        .total_unknown, .total_filled, .total_blank
    );
endmodule
`default_nettype wire

// ===== rtl/gms_front.sv =====
// Front stage: accepts items, range-checks against sizes in use, classifies.
// Depends on gms_pkg.
`default_nettype none
module gms_front #(
    parameter int MAX_ROWS = gms_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gms_pkg::MAX_COLS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic                       cfg_index,
    input  wire logic [gms_pkg::CFG_W-1:0]  cfg_data,
    input  wire logic                       valid,
    output logic                            ready,
    input  wire logic [1:0]                 opcode,
    input  wire logic [gms_pkg::IDX_W-1:0]  row_index,
    input  wire logic [gms_pkg::IDX_W-1:0]  col_index,
    input  wire logic                       mark_value,
    output logic                            cmd_valid,
    input  wire logic                       cmd_ready,
    output gms_pkg::cmd_t                   cmd
);
    import gms_pkg::*;

    logic [CFG_W-1:0] rows_reg, cols_reg;
    logic [CFG_W-1:0] nr, nc;
    cmd_t             q_reg [2];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    cmd_t             c_new;
    logic             push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= CFG_W'(64);
            cols_reg <= CFG_W'(64);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_ROWS) rows_reg <= cfg_data;
            else                       cols_reg <= cfg_data;
        end
    end

    assign nr = (int'(rows_reg) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : rows_reg;
    assign nc = (int'(cols_reg) > MAX_COLS) ? CFG_W'(MAX_COLS) : cols_reg;

    always_comb
    begin
        c_new.range_err = ({1'b0, row_index} >= nr) || ({1'b0, col_index} >= nc);
        c_new.wr_fill   = (opcode == OP_FILL);
        c_new.wr_blank  = (opcode == OP_BLANK);
        c_new.mark      = mark_value;
        c_new.row       = row_index;
        c_new.col       = col_index;
        c_new.nr        = nr;
        c_new.nc        = nc;
    end

    assign ready     = (cnt_reg != 2'd2);
    assign push      = valid && ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= c_new;
    end
endmodule
`default_nettype wire

// ===== rtl/gms_back.sv =====
// Back stage: clears the mark memory after reset, then does one read-modify-write
// per item over marks and counters and registers the result. Depends on gms_pkg.
`default_nettype none
module gms_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cmd_valid,
    output logic                            cmd_ready,
    input  wire gms_pkg::cmd_t              cmd,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [1:0]                      error_code,
    output logic                            cell_filled,
    output logic                            cell_blank,
    output logic [gms_pkg::CNT_W-1:0]       row_unknown,
    output logic [gms_pkg::CNT_W-1:0]       row_filled,
    output logic [gms_pkg::CNT_W-1:0]       row_blank,
    output logic [gms_pkg::CNT_W-1:0]       col_unknown,
    output logic [gms_pkg::CNT_W-1:0]       col_filled,
    output logic [gms_pkg::CNT_W-1:0]       col_blank,
    output logic [gms_pkg::TOT_W-1:0]       total_unknown,
    output logic [gms_pkg::TOT_W-1:0]       total_filled,
    output logic [gms_pkg::TOT_W-1:0]       total_blank
);
    import gms_pkg::*;
    localparam int CELLS = 64 * 64;
    localparam int AW    = 2 * IDX_W;

    st_t              st_reg, st_next;
    logic [AW:0]      clr_reg;
    logic [1:0]       mem [CELLS];
    logic [1:0]       rd_reg;
    logic [CNT_W-1:0] rf_mem [64], rb_mem [64], cf_mem [64], cb_mem [64];
    logic [CNT_W-1:0] rf_reg, rb_reg, cf_reg, cb_reg;
    logic [TOT_W-1:0] tf_reg, tb_reg;
    cmd_t             c_reg;

    logic [AW-1:0]    addr;
    logic             conflict, change, up;
    logic [1:0]       nmark;
    logic [CNT_W-1:0] nrf, nrb, ncf, ncb;
    logic [TOT_W-1:0] ntf, ntb;
    logic             mem_we, cnt_we, ld_out, clr_we;
    logic [AW-1:0]    wa;
    logic [1:0]       wd;

    assign addr = {c_reg.row, c_reg.col};
    assign up   = c_reg.mark;
    assign conflict = up && ((c_reg.wr_fill && rd_reg[1]) || (c_reg.wr_blank && rd_reg[0]));
    assign change = !c_reg.range_err && !conflict &&
                    ((c_reg.wr_fill && rd_reg[0] != up) || (c_reg.wr_blank && rd_reg[1] != up));

    function automatic logic [CNT_W-1:0] bmp7(logic [CNT_W-1:0] v, logic u);
        bmp7 = u ? v + 1'b1 : (v != '0 ? v - 1'b1 : v);
    endfunction
    function automatic logic [TOT_W-1:0] bmp13(logic [TOT_W-1:0] v, logic u);
        bmp13 = u ? v + 1'b1 : (v != '0 ? v - 1'b1 : v);
    endfunction

    always_comb
    begin
        nmark = rd_reg;
        nrf = rf_reg; nrb = rb_reg; ncf = cf_reg; ncb = cb_reg;
        ntf = tf_reg; ntb = tb_reg;
        if (change && c_reg.wr_fill)
        begin
            nmark[0] = up;
            nrf = bmp7(rf_reg, up); ncf = bmp7(cf_reg, up); ntf = bmp13(tf_reg, up);
        end
        if (change && c_reg.wr_blank)
        begin
            nmark[1] = up;
            nrb = bmp7(rb_reg, up); ncb = bmp7(cb_reg, up); ntb = bmp13(tb_reg, up);
        end
    end

    always_comb
    begin
        st_next   = st_reg;
        cmd_ready = 1'b0;
        ld_out    = 1'b0;
        clr_we    = 1'b0;
        unique case (st_reg)
            ST_CLEAR:
            begin
                clr_we = 1'b1;
                if (clr_reg[AW]) st_next = ST_READ;
            end
            ST_READ:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid) st_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                ld_out = !out_valid || out_ready;
                if (ld_out) st_next = ST_READ;
                else        st_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                ld_out = !out_valid || out_ready;
                if (ld_out) st_next = ST_READ;
            end
            default: st_next = ST_READ;
        endcase
    end

    assign mem_we = ld_out && change;
    assign cnt_we = mem_we;
    assign wa = clr_we ? clr_reg[AW-1:0] : addr;
    assign wd = clr_we ? 2'b00 : nmark;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_CLEAR;
            clr_reg   <= '0;
            out_valid <= 1'b0;
            tf_reg    <= '0;
            tb_reg    <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (clr_we) clr_reg <= clr_reg + 1'b1;
            if (ld_out) out_valid <= 1'b1;
            else if (out_ready) out_valid <= 1'b0;
            if (cnt_we)
            begin
                tf_reg <= ntf;
                tb_reg <= ntb;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_we || mem_we) mem[wa] <= wd;
        if (clr_we && clr_reg[AW-1:AW-IDX_W] == '0)
        begin
            rf_mem[clr_reg[IDX_W-1:0]] <= '0;
            rb_mem[clr_reg[IDX_W-1:0]] <= '0;
            cf_mem[clr_reg[IDX_W-1:0]] <= '0;
            cb_mem[clr_reg[IDX_W-1:0]] <= '0;
        end
        else if (cnt_we)
        begin
            rf_mem[c_reg.row] <= nrf;
            rb_mem[c_reg.row] <= nrb;
            cf_mem[c_reg.col] <= ncf;
            cb_mem[c_reg.col] <= ncb;
        end
        if (cmd_ready && cmd_valid)
        begin
            c_reg  <= cmd;
            rd_reg <= mem[{cmd.row, cmd.col}];
            rf_reg <= rf_mem[cmd.row];
            rb_reg <= rb_mem[cmd.row];
            cf_reg <= cf_mem[cmd.col];
            cb_reg <= cb_mem[cmd.col];
        end
    end

    function automatic logic [TOT_W-1:0] sat(logic [TOT_W-1:0] a, logic [TOT_W-1:0] b,
                                             logic [TOT_W-1:0] c);
        logic [TOT_W:0] u;
        u = {1'b0, b} + {1'b0, c};
        sat = (u >= {1'b0, a}) ? '0 : TOT_W'({1'b0, a} - u);
    endfunction

    logic [TOT_W-1:0] area;
    assign area = TOT_W'(c_reg.nr) * TOT_W'(c_reg.nc);

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            if (c_reg.range_err || conflict)
            begin
                error_code  <= c_reg.range_err ? ERR_RANGE : ERR_CONFLICT;
                cell_filled <= 1'b0; cell_blank <= 1'b0;
                row_unknown <= '0; row_filled <= '0; row_blank <= '0;
                col_unknown <= '0; col_filled <= '0; col_blank <= '0;
                total_unknown <= '0; total_filled <= '0; total_blank <= '0;
            end
            else
            begin
                error_code  <= ERR_OK;
                cell_filled <= nmark[0];
                cell_blank  <= nmark[1];
                row_filled  <= nrf; row_blank <= nrb;
                col_filled  <= ncf; col_blank <= ncb;
                row_unknown <= CNT_W'(sat(TOT_W'(c_reg.nc), TOT_W'(nrf), TOT_W'(nrb)));
                col_unknown <= CNT_W'(sat(TOT_W'(c_reg.nr), TOT_W'(ncf), TOT_W'(ncb)));
                total_filled <= ntf; total_blank <= ntb;
                total_unknown <= sat(area, ntf, ntb);
            end
        end
    end
endmodule
`default_nettype wire
